[rtl/tdpc_pkg.sv]
// ----------------------------------------------------------------------------
// tdpc_pkg: shared types and constants for the tracker drive position controller
// Holds the command codes, drive codes, register indexes and reset values,
// the port widths, the state struct and the config register struct.
// ----------------------------------------------------------------------------
package tdpc_pkg;

  typedef enum logic [3:0] {
    CMD_TICK      = 4'd0,
    CMD_GOTO      = 4'd1,
    CMD_TIMED     = 4'd2,
    CMD_HOME      = 4'd3,
    CMD_ABORT     = 4'd4,
    CMD_RET_START = 4'd5,
    CMD_AUTO_ON   = 4'd6,
    CMD_AUTO_OFF  = 4'd7,
    CMD_CLR_ERR   = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    DRV_OFF  = 2'd0,
    DRV_WEST = 2'd1,
    DRV_EAST = 2'd2
  } drv_t;

  localparam logic [1:0] REG_CHANGE_LOCK = 2'd0;
  localparam logic [1:0] REG_STALL       = 2'd1;
  localparam logic [1:0] REG_MIN_TRAVEL  = 2'd2;

  localparam logic [15:0] CHANGE_LOCK_RST = 16'd5000;
  localparam logic [15:0] STALL_RST       = 16'd10000;
  localparam logic [15:0] MIN_TRAVEL_RST  = 16'd20;

  localparam int IN_W  = 72;
  localparam int OUT_W = 64;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] last_change_ms;
    logic [31:0] last_motion_ms;
    logic [31:0] stop_at_ms;
    logic [1:0]  drive_state;
    logic [1:0]  prior_direction;
    logic [31:0] goal_position;
    logic        seek_active;
    logic [31:0] position_count;
    logic [31:0] max_position;
    logic [31:0] start_position;
    logic [31:0] end_position;
    logic        flg_init;
    logic        flg_auto;
    logic        flg_err;
    logic [2:0]  home_step;
    logic [1:0]  light_step;
    logic [15:0] failure_count;
    logic        led_bit;
  } ctl_state_t;

  typedef struct packed {
    logic [15:0] change_lock_ms;
    logic [15:0] stall_timeout_ms;
    logic [15:0] min_travel;
  } cfg_regs_t;

endpackage

[rtl/tracker_drive_position_controller_unit.sv]
// ----------------------------------------------------------------------------
// tracker_drive_position_controller_unit: two-relay tracker drive controller
// Goto, timed runs, stall error, homing and return to start on millisecond tick words.
// ----------------------------------------------------------------------------
// One word is taken every cycle unless the output stalls: the command is
// applied to the state registers in a single pass of compare/add logic and
// the result word is loaded into an output register in the same edge. A
// new word is taken in the same cycle that the last result is taken,
// and input stalls only while that register holds an untaken result.
module tracker_drive_position_controller_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // cmd[3:0], pulse_delta[19:4], target_value[51:20], run_west[52],
  // duration_ms[68:53], zero fill
  input  logic [tdpc_pkg::IN_W-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // motor_on[0], motor_west[1], drive_report[4:2], position_now[36:5],
  // initialised[37], auto_mode[38], error_flag[39], homing_busy[40],
  // seeking[41], led_level[42], failure_pulses[58:43], zero fill
  output logic [tdpc_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [15:0]               cfg_data
);

  tdpc_pkg::ctl_state_t st, st_next;
  tdpc_pkg::cfg_regs_t  cfg;
  logic [63:0]          res_word;
  logic                 take;

  // accept while the result register is empty or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.change_lock_ms   <= tdpc_pkg::CHANGE_LOCK_RST;
      cfg.stall_timeout_ms <= tdpc_pkg::STALL_RST;
      cfg.min_travel       <= tdpc_pkg::MIN_TRAVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tdpc_pkg::REG_CHANGE_LOCK: cfg.change_lock_ms   <= cfg_data;
        tdpc_pkg::REG_STALL:       cfg.stall_timeout_ms <= cfg_data;
        tdpc_pkg::REG_MIN_TRAVEL:  cfg.min_travel       <= cfg_data;
        default: ;
      endcase
    end
  end

  // single-pass command step
  tdpc_core u_core (
    .cur          (st),
    .cfg          (cfg),
    .cmd          (s_axis_tdata[3:0]),
    .pulse_delta  (s_axis_tdata[19:4]),
    .target_value (s_axis_tdata[51:20]),
    .run_west     (s_axis_tdata[52]),
    .duration_ms  (s_axis_tdata[68:53]),
    .nxt          (st_next)
  );

  // result formatting from the state after the command
  tdpc_report u_report (
    .st             (st_next),
    .change_lock_ms (cfg.change_lock_ms),
    .word           (res_word)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= res_word;
    end
  end

  // a result waiting and not taken blocks input
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted over a pending result");

  // every accepted word yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    take |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // the drive never sits in an undefined code
  a_drive_code: assert property (@(posedge clk) disable iff (rst)
    st.drive_state != 2'd3)
    else $error("drive state code 3 reached");

endmodule

[rtl/tdpc_core.sv]
// ----------------------------------------------------------------------------
// tdpc_core: next-state logic for one command
// Combinational step of the drive controller from the current state.
// ----------------------------------------------------------------------------
module tdpc_core (
  input  tdpc_pkg::ctl_state_t cur,
  input  tdpc_pkg::cfg_regs_t  cfg,
  input  logic [3:0]           cmd,
  input  logic [15:0]          pulse_delta,
  input  logic [31:0]          target_value,
  input  logic                 run_west,
  input  logic [15:0]          duration_ms,
  output tdpc_pkg::ctl_state_t nxt
);

  logic [31:0] lock32;
  logic [31:0] stall32;
  assign lock32  = {16'd0, cfg.change_lock_ms};
  assign stall32 = {16'd0, cfg.stall_timeout_ms};

  // drive request applied to a working copy
  function automatic tdpc_pkg::ctl_state_t drv_req(input tdpc_pkg::ctl_state_t s,
                                                   input logic [1:0] req_in,
                                                   input logic [31:0] lk);
    tdpc_pkg::ctl_state_t o;
    logic [1:0] req;
    o   = s;
    req = s.flg_err ? tdpc_pkg::DRV_OFF : req_in;
    if (req == tdpc_pkg::DRV_OFF) begin
      o.drive_state    = tdpc_pkg::DRV_OFF;
      o.last_change_ms = s.now_ms;
    end else if (req != tdpc_pkg::DRV_WEST && req != tdpc_pkg::DRV_EAST) begin
      o = s;
    end else if ((s.last_change_ms + lk) > s.now_ms) begin
      o = s;
    end else if (s.drive_state != tdpc_pkg::DRV_OFF && s.drive_state != req) begin
      o.drive_state    = tdpc_pkg::DRV_OFF;
      o.last_change_ms = s.now_ms;
    end else begin
      o.drive_state     = req;
      o.prior_direction = req;
      o.last_change_ms  = s.now_ms;
      o.last_motion_ms  = s.now_ms;
    end
    return o;
  endfunction

  function automatic tdpc_pkg::ctl_state_t go_to(input tdpc_pkg::ctl_state_t s,
                                                 input logic [31:0] v,
                                                 input logic [31:0] lk);
    tdpc_pkg::ctl_state_t o;
    o = s;
    if (s.flg_init && v <= s.max_position && s.drive_state == tdpc_pkg::DRV_OFF) begin
      if (v > s.position_count) begin
        o = drv_req(s, tdpc_pkg::DRV_WEST, lk);
        o.goal_position = v;
        o.seek_active   = 1'b1;
      end else if (v < s.position_count) begin
        o = drv_req(s, tdpc_pkg::DRV_EAST, lk);
        o.goal_position = v;
        o.seek_active   = 1'b1;
      end
    end
    return o;
  endfunction

  tdpc_pkg::ctl_state_t t0, t1, th, tl, tn;
  logic [2:0]  rep;
  logic [15:0] fail_sum;
  logic [31:0] travel;

  always_comb begin
    nxt      = cur;
    t0       = cur;
    t1       = cur;
    th       = cur;
    tl       = cur;
    tn       = cur;
    rep      = 3'd0;
    fail_sum = 16'd0;
    travel   = 32'd0;
    case (cmd)
      tdpc_pkg::CMD_TICK: begin
        t0.now_ms = cur.now_ms + 32'd1;
        if (t0.drive_state == tdpc_pkg::DRV_OFF &&
            t0.now_ms < (t0.last_change_ms + lock32))
          rep = {1'b0, t0.prior_direction} + 3'd2;
        else
          rep = {1'b0, t0.drive_state};
        if (pulse_delta != 16'd0) begin
          if (rep == 3'd1 || rep == 3'd3)
            t0.position_count = t0.position_count + {16'd0, pulse_delta};
          else if (rep == 3'd2 || rep == 3'd4)
            t0.position_count = t0.position_count - {16'd0, pulse_delta};
          else begin
            fail_sum = t0.failure_count + pulse_delta;
            t0.failure_count = fail_sum;
            if ({16'd0, fail_sum} >= t0.start_position ||
                {16'd0, fail_sum} >= (t0.max_position - t0.end_position)) begin
              t0.flg_init = 1'b0;
              t0.flg_auto = 1'b0;
            end
          end
          t0.led_bit        = ~t0.led_bit;
          t0.last_motion_ms = t0.now_ms;
        end
        if (t0.home_step != 3'd0) begin
          th = t0;
          case (t0.home_step)
            3'd1: begin
              th.flg_init = 1'b0;
              th = drv_req(th, tdpc_pkg::DRV_WEST, lock32);
              th.last_motion_ms = th.now_ms;
              th.home_step = 3'd2;
            end
            3'd2: begin
              if ((t0.last_motion_ms + stall32) < t0.now_ms) begin
                th.position_count = 32'hFFFF_FFFF;
                th = drv_req(th, tdpc_pkg::DRV_OFF, lock32);
                th.last_motion_ms = th.now_ms;
                th.home_step = 3'd3;
              end
            end
            3'd3: begin
              if ((t0.last_motion_ms + lock32) < t0.now_ms) begin
                th = drv_req(th, tdpc_pkg::DRV_EAST, lock32);
                th.last_motion_ms = th.now_ms;
                th.home_step = 3'd4;
              end
            end
            3'd4: begin
              if ((t0.last_motion_ms + stall32) < t0.now_ms) begin
                th = drv_req(th, tdpc_pkg::DRV_OFF, lock32);
                travel = 32'd1 - t0.position_count;
                th.max_position = travel;
                th.home_step = 3'd0;
                if (travel >= {16'd0, cfg.min_travel}) begin
                  th.position_count = 32'd0;
                  th.end_position   = travel - 32'd1;
                  th.start_position = 32'd1;
                  th.flg_init       = 1'b1;
                  th.failure_count  = 16'd0;
                end
              end
            end
            default: th.home_step = 3'd0;
          endcase
          nxt = th;
        end else if (t0.light_step != 2'd0) begin
          tl = t0;
          case (t0.light_step)
            2'd1: begin
              if ((t0.last_motion_ms + lock32) < t0.now_ms) begin
                tl = drv_req(tl, tdpc_pkg::DRV_EAST, lock32);
                tl.last_motion_ms = tl.now_ms;
                tl.light_step = 2'd2;
              end
            end
            2'd2: begin
              if ((t0.last_motion_ms + stall32) < t0.now_ms) begin
                tl = drv_req(tl, tdpc_pkg::DRV_OFF, lock32);
                tl.position_count = 32'd0;
                tl.light_step = 2'd3;
              end
            end
            default: begin
              if ((t0.last_change_ms + lock32) < t0.now_ms) begin
                tl = go_to(tl, tl.start_position, lock32);
                tl.failure_count = 16'd0;
                tl.light_step = 2'd0;
              end
            end
          endcase
          nxt = tl;
        end else begin
          t1 = t0;
          if (t1.stop_at_ms != 32'd0 && t1.stop_at_ms <= t1.now_ms) begin
            t1 = drv_req(t1, tdpc_pkg::DRV_OFF, lock32);
            t1.stop_at_ms = 32'd0;
          end
          if ((t1.last_motion_ms + stall32) < t1.now_ms &&
              t1.drive_state != tdpc_pkg::DRV_OFF && t1.flg_auto) begin
            t1 = drv_req(t1, tdpc_pkg::DRV_OFF, lock32);
            t1.flg_auto = 1'b0;
            t1.flg_err  = 1'b1;
          end
          tn = t1;
          if (t1.seek_active &&
              ((t1.drive_state == tdpc_pkg::DRV_WEST &&
                (t1.position_count >= t1.goal_position ||
                 t1.position_count >= t1.max_position)) ||
               (t1.drive_state == tdpc_pkg::DRV_EAST &&
                (t1.position_count <= t1.goal_position ||
                 t1.position_count == 32'd0)))) begin
            tn = drv_req(t1, tdpc_pkg::DRV_OFF, lock32);
            tn.goal_position = 32'd0;
            tn.seek_active   = 1'b0;
          end
          nxt = tn;
        end
      end
      tdpc_pkg::CMD_GOTO: nxt = go_to(cur, target_value, lock32);
      tdpc_pkg::CMD_TIMED: begin
        if (!cur.flg_auto && !cur.flg_err && cur.drive_state == tdpc_pkg::DRV_OFF) begin
          t1 = cur;
          t1.stop_at_ms = cur.now_ms + {16'd0, duration_ms};
          nxt = drv_req(t1, run_west ? tdpc_pkg::DRV_WEST : tdpc_pkg::DRV_EAST, lock32);
        end
      end
      tdpc_pkg::CMD_HOME:      nxt.home_step  = 3'd1;
      tdpc_pkg::CMD_ABORT:     nxt.home_step  = 3'd0;
      tdpc_pkg::CMD_RET_START: nxt.light_step = 2'd1;
      tdpc_pkg::CMD_AUTO_ON:   nxt.flg_auto   = 1'b1;
      tdpc_pkg::CMD_AUTO_OFF:  nxt.flg_auto   = 1'b0;
      tdpc_pkg::CMD_CLR_ERR:   nxt.flg_err    = 1'b0;
      default: nxt = cur;
    endcase
  end

endmodule

[rtl/tdpc_report.sv]
// ----------------------------------------------------------------------------
// tdpc_report: result word formatting
// Builds the packed result word from the controller state.
// ----------------------------------------------------------------------------
module tdpc_report (
  input  tdpc_pkg::ctl_state_t st,
  input  logic [15:0]          change_lock_ms,
  output logic [63:0]          word
);

  logic [2:0] rep;

  always_comb begin
    if (st.drive_state == tdpc_pkg::DRV_OFF &&
        st.now_ms < (st.last_change_ms + {16'd0, change_lock_ms}))
      rep = {1'b0, st.prior_direction} + 3'd2;
    else
      rep = {1'b0, st.drive_state};
  end

  assign word = {5'd0, st.failure_count, st.led_bit, st.seek_active,
                 (st.home_step != 3'd0) || (st.light_step != 2'd0),
                 st.flg_err, st.flg_auto, st.flg_init, st.position_count, rep,
                 st.drive_state == tdpc_pkg::DRV_WEST,
                 st.drive_state != tdpc_pkg::DRV_OFF};

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the tracker drive position controller
// Streams command words into the unit, computes every result word with an
// independent model of the drive, lock, homing and goto logic, and compares
// the unit's result words field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // cmd[3:0], pulse_delta[19:4], target_value[51:20], run_west[52],
  // duration_ms[68:53], zero fill
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // motor_on[0], motor_west[1], drive_report[4:2], position_now[36:5],
  // initialised[37], auto_mode[38], error_flag[39], homing_busy[40],
  // seeking[41], led_level[42], failure_pulses[58:43], zero fill
  logic [63:0] m_axis_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // result word layout, lowest field last
  typedef struct packed {
    logic [4:0]  fill;
    logic [15:0] failure_pulses;
    logic        led_level;
    logic        seeking;
    logic        homing_busy;
    logic        error_flag;
    logic        auto_mode;
    logic        initialised;
    logic [31:0] position_now;
    logic [2:0]  drive_report;
    logic        motor_west;
    logic        motor_on;
  } status_word_t;

  tracker_drive_position_controller_unit DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------- drive model
  logic [31:0] lock_ms, stall_ms, travel_min;
  logic [31:0] clock_ms, changed_ms, moved_ms, stop_ms;
  tdpc_pkg::drv_t relay, last_dir;
  logic [31:0] goal, pos, pos_max, pos_start, pos_end;
  logic        seek_on, init_f, auto_f, err_f, led;
  logic [2:0]  home_ph;
  logic [1:0]  light_ph;
  logic [15:0] fail_cnt;

  // relay request with error override and dead-time lock
  function automatic void relay_request(tdpc_pkg::drv_t req);
    logic [31:0] free_at;
    free_at = changed_ms + lock_ms;
    if (err_f) req = tdpc_pkg::DRV_OFF;
    if (req == tdpc_pkg::DRV_OFF) begin
      relay = tdpc_pkg::DRV_OFF;
      changed_ms = clock_ms;
      return;
    end
    if (free_at > clock_ms) return;
    if (relay != tdpc_pkg::DRV_OFF && relay != req) begin
      // reversal only switches off
      relay = tdpc_pkg::DRV_OFF;
      changed_ms = clock_ms;
      return;
    end
    relay = req;
    last_dir = req;
    changed_ms = clock_ms;
    moved_ms = clock_ms;
  endfunction

  // reported drive code, run-after while the lock still holds after a stop
  function automatic logic [2:0] drive_code();
    logic [31:0] free_at;
    free_at = changed_ms + lock_ms;
    if (relay == tdpc_pkg::DRV_OFF && clock_ms < free_at) return 3'(last_dir) + 3'd2;
    return 3'(relay);
  endfunction

  function automatic void seek_to(logic [31:0] v);
    if (!init_f || v > pos_max || relay != tdpc_pkg::DRV_OFF) return;
    if (v > pos) begin
      goal = v;
      relay_request(tdpc_pkg::DRV_WEST);
      seek_on = 1'b1;
    end else if (v < pos) begin
      goal = v;
      relay_request(tdpc_pkg::DRV_EAST);
      seek_on = 1'b1;
    end
  endfunction

  // four-step homing: west to stop, pause, east to stop, measure
  function automatic void home_advance();
    logic [31:0] stall_at, lock_at;
    stall_at = moved_ms + stall_ms;
    lock_at = moved_ms + lock_ms;
    case (home_ph)
      3'd1: begin
        init_f = 1'b0;
        relay_request(tdpc_pkg::DRV_WEST);
        moved_ms = clock_ms;
        home_ph = 3'd2;
      end
      3'd2: if (stall_at < clock_ms) begin
        pos = 32'hFFFF_FFFF;
        relay_request(tdpc_pkg::DRV_OFF);
        moved_ms = clock_ms;
        home_ph = 3'd3;
      end
      3'd3: if (lock_at < clock_ms) begin
        relay_request(tdpc_pkg::DRV_EAST);
        moved_ms = clock_ms;
        home_ph = 3'd4;
      end
      3'd4: if (stall_at < clock_ms) begin
        relay_request(tdpc_pkg::DRV_OFF);
        pos_max = 32'd0 - pos + 32'd1;
        home_ph = 3'd0;
        // travel too short: homing ends uninitialised
        if (pos_max >= travel_min) begin
          pos = '0;
          pos_end = pos_max - 32'd1;
          pos_start = 32'd1;
          init_f = 1'b1;
          fail_cnt = '0;
        end
      end
      default: home_ph = 3'd0;
    endcase
  endfunction

  // return to start: east to stop, zero, then goto start
  function automatic void light_advance();
    logic [31:0] stall_at, lock_at, chg_at;
    stall_at = moved_ms + stall_ms;
    lock_at = moved_ms + lock_ms;
    chg_at = changed_ms + lock_ms;
    case (light_ph)
      2'd1: if (lock_at < clock_ms) begin
        relay_request(tdpc_pkg::DRV_EAST);
        moved_ms = clock_ms;
        light_ph = 2'd2;
      end
      2'd2: if (stall_at < clock_ms) begin
        relay_request(tdpc_pkg::DRV_OFF);
        pos = '0;
        light_ph = 2'd3;
      end
      2'd3: if (chg_at < clock_ms) begin
        seek_to(pos_start);
        fail_cnt = '0;
        light_ph = 2'd0;
      end
      default: light_ph = 2'd0;
    endcase
  endfunction

  function automatic void tick_advance(logic [15:0] pulses);
    logic [2:0]  code;
    logic [31:0] stall_at;
    clock_ms = clock_ms + 32'd1;
    if (pulses != 16'd0) begin
      code = drive_code();
      if (code == 3'd1 || code == 3'd3) pos = pos + 32'(pulses);
      else if (code == 3'd2 || code == 3'd4) pos = pos - 32'(pulses);
      else begin
        // pulses with the drive off count as failures
        fail_cnt = fail_cnt + pulses;
        if (32'(fail_cnt) >= pos_start || 32'(fail_cnt) >= pos_max - pos_end) begin
          init_f = 1'b0;
          auto_f = 1'b0;
        end
      end
      led = ~led;
      moved_ms = clock_ms;
    end
    if (home_ph != 3'd0) begin
      home_advance();
      return;
    end
    if (light_ph != 2'd0) begin
      light_advance();
      return;
    end
    if (stop_ms > 32'd0 && stop_ms <= clock_ms) begin
      relay_request(tdpc_pkg::DRV_OFF);
      stop_ms = '0;
    end
    stall_at = moved_ms + stall_ms;
    if (stall_at < clock_ms && relay != tdpc_pkg::DRV_OFF && auto_f) begin
      relay_request(tdpc_pkg::DRV_OFF);
      auto_f = 1'b0;
      err_f = 1'b1;
    end
    if (!seek_on) return;
    if ((relay == tdpc_pkg::DRV_WEST && (pos >= goal || pos >= pos_max)) ||
        (relay == tdpc_pkg::DRV_EAST && (pos <= goal || pos == 32'd0))) begin
      relay_request(tdpc_pkg::DRV_OFF);
      goal = '0;
      seek_on = 1'b0;
    end
  endfunction

  // apply one command word and return the status word it produces
  function automatic status_word_t apply_command(logic [71:0] w);
    logic [3:0]  op;
    status_word_t s;
    op = w[3:0];
    case (op)
      tdpc_pkg::CMD_TICK: tick_advance(w[19:4]);
      tdpc_pkg::CMD_GOTO: seek_to(w[51:20]);
      tdpc_pkg::CMD_TIMED: if (!auto_f && !err_f && relay == tdpc_pkg::DRV_OFF) begin
        stop_ms = clock_ms + 32'(w[68:53]);
        relay_request(w[52] ? tdpc_pkg::DRV_WEST : tdpc_pkg::DRV_EAST);
      end
      tdpc_pkg::CMD_HOME:      home_ph = 3'd1;
      tdpc_pkg::CMD_ABORT:     home_ph = 3'd0;
      tdpc_pkg::CMD_RET_START: light_ph = 2'd1;
      tdpc_pkg::CMD_AUTO_ON:   auto_f = 1'b1;
      tdpc_pkg::CMD_AUTO_OFF:  auto_f = 1'b0;
      tdpc_pkg::CMD_CLR_ERR:   err_f = 1'b0;
      default: ;
    endcase
    s = '0;
    s.motor_on = relay != tdpc_pkg::DRV_OFF;
    s.motor_west = relay == tdpc_pkg::DRV_WEST;
    s.drive_report = drive_code();
    s.position_now = pos;
    s.initialised = init_f;
    s.auto_mode = auto_f;
    s.error_flag = err_f;
    s.homing_busy = home_ph != 3'd0 || light_ph != 2'd0;
    s.seeking = seek_on;
    s.led_level = led;
    s.failure_pulses = fail_cnt;
    return s;
  endfunction

  // ------------------------------------------------------------ clock, limit
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------- driver, monitor
  logic [71:0]  cmd_words[$];
  status_word_t expected_status[$];
  int           cyc;
  bit           word_taken;
  int           errors;

  // a long calm stretch with no idling on either side
  function automatic bit idle_now();
    if (cyc >= 1000 && cyc < 1600) return 1'b0;
    return $urandom_range(0, 99) < 18;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !idle_now();
      // hold the word until it is taken
      if (!s_axis_tvalid || word_taken) begin
        if (cmd_words.size() != 0 && !idle_now()) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= cmd_words.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, fname, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    status_word_t want, got;
    cyc <= cyc + 1;
    word_taken = s_axis_tvalid && s_axis_tready && !rst;
    // compare before predicting: each result word comes out of an output register after its input
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected word expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_status.pop_front();
        check_field("motor_on", want.motor_on, got.motor_on);
        check_field("motor_west", want.motor_west, got.motor_west);
        check_field("drive_report", want.drive_report, got.drive_report);
        check_field("position_now", want.position_now, got.position_now);
        check_field("initialised", want.initialised, got.initialised);
        check_field("auto_mode", want.auto_mode, got.auto_mode);
        check_field("error_flag", want.error_flag, got.error_flag);
        check_field("homing_busy", want.homing_busy, got.homing_busy);
        check_field("seeking", want.seeking, got.seeking);
        check_field("led_level", want.led_level, got.led_level);
        check_field("failure_pulses", want.failure_pulses, got.failure_pulses);
        check_field("fill", want.fill, got.fill);
      end
    end
    if (word_taken) expected_status.push_back(apply_command(s_axis_tdata));
  end

  // ---------------------------------------------------------------- stimulus
  int n_items;

  task automatic send(logic [3:0] op, logic [15:0] pulses = '0, logic [31:0] target = '0,
                      logic west = 1'b0, logic [15:0] dur = '0);
    cmd_words.push_back({3'b000, dur, west, target, pulses, op});
    n_items++;
  endtask

  task automatic ticks(int n, int pmax);
    repeat (n) send(tdpc_pkg::CMD_TICK, 16'($urandom_range(0, pmax)));
  endtask

  // wait until everything is through, then let the unit settle
  task automatic drain();
    do @(posedge clk);
    while (cmd_words.size() != 0 || s_axis_tvalid || expected_status.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      tdpc_pkg::REG_CHANGE_LOCK: lock_ms = 32'(val);
      tdpc_pkg::REG_STALL:       stall_ms = 32'(val);
      default:                   travel_min = 32'(val);
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [15:0] lk, logic [15:0] st, logic [15:0] mt);
    drain();
    write_reg(tdpc_pkg::REG_CHANGE_LOCK, lk);
    write_reg(tdpc_pkg::REG_STALL, st);
    write_reg(tdpc_pkg::REG_MIN_TRAVEL, mt);
  endtask

  // random run of mostly well-formed sequences
  task automatic random_phase(int count, int wait_len);
    int stop_at;
    stop_at = n_items + count;
    while (n_items < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // full homing with random pulse bursts and end-stop pauses
          send(tdpc_pkg::CMD_HOME);
          ticks($urandom_range(2, 12), 6);
          ticks(wait_len, 0);
          ticks(wait_len, 0);
          ticks($urandom_range(3, 25), 6);
          ticks(wait_len + 2, 0);
        end
        2: begin
          send(tdpc_pkg::CMD_RET_START);
          ticks(wait_len, 0);
          ticks($urandom_range(1, 8), 4);
          ticks(2 * wait_len + 2, 0);
        end
        3, 4: begin
          send(tdpc_pkg::CMD_GOTO, '0, $urandom_range(0, 40));
          ticks($urandom_range(1, 30), 3);
        end
        5: begin
          send(tdpc_pkg::CMD_TIMED, '0, '0, 1'($urandom), 16'($urandom_range(0, 12)));
          ticks($urandom_range(1, 15), 3);
        end
        6: begin
          send(tdpc_pkg::CMD_AUTO_ON);
          send(tdpc_pkg::CMD_GOTO, '0, $urandom_range(0, 40));
          ticks($urandom_range(1, wait_len + 4), 1);
          ticks(wait_len + 2, 0);
          send(tdpc_pkg::CMD_CLR_ERR);
        end
        7: begin
          send(tdpc_pkg::CMD_HOME);
          ticks($urandom_range(1, 6), 3);
          send(tdpc_pkg::CMD_ABORT);
          ticks($urandom_range(1, 6), 3);
        end
        default: begin
          // noise: any code, any field values
          send(4'($urandom), 16'($urandom), $urandom, 1'($urandom), 16'($urandom));
          send(tdpc_pkg::CMD_TICK, 16'($urandom));
          ticks($urandom_range(0, 4), 2);
        end
      endcase
    end
  endtask

  initial begin
    logic [3:0] op;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cyc = 0;
    errors = 0;
    n_items = 0;
    lock_ms = 32'(tdpc_pkg::CHANGE_LOCK_RST);
    stall_ms = 32'(tdpc_pkg::STALL_RST);
    travel_min = 32'(tdpc_pkg::MIN_TRAVEL_RST);
    {clock_ms, changed_ms, moved_ms, stop_ms} = '0;
    relay = tdpc_pkg::DRV_OFF;
    last_dir = tdpc_pkg::DRV_OFF;
    {goal, pos, pos_max, pos_start, pos_end} = '0;
    {seek_on, init_f, auto_f, err_f, led} = '0;
    home_ph = '0;
    light_ph = '0;
    fail_cnt = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: run-after right after reset, refused goto and timed run,
    // field extremes and every command code including unused ones
    send(tdpc_pkg::CMD_TICK);
    send(tdpc_pkg::CMD_TICK, 16'hFFFF);
    send(tdpc_pkg::CMD_GOTO, '0, 32'hFFFF_FFFF);
    send(tdpc_pkg::CMD_GOTO, '0, 32'd0);
    send(tdpc_pkg::CMD_TIMED, '0, '0, 1'b1, 16'hFFFF);
    send(tdpc_pkg::CMD_TIMED, '0, '0, 1'b0, 16'd0);
    send(tdpc_pkg::CMD_AUTO_ON);
    send(tdpc_pkg::CMD_TIMED, '0, '0, 1'b1, 16'd5);
    send(tdpc_pkg::CMD_AUTO_OFF);
    send(tdpc_pkg::CMD_CLR_ERR);
    send(tdpc_pkg::CMD_HOME);
    send(tdpc_pkg::CMD_TICK, 16'h5555);
    send(tdpc_pkg::CMD_ABORT);
    send(tdpc_pkg::CMD_RET_START);
    send(tdpc_pkg::CMD_TICK, 16'hAAAA);
    for (op = tdpc_pkg::CMD_CLR_ERR + 4'd1; op != 4'd0; op++)
      send(op, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    send(tdpc_pkg::CMD_TICK, 16'd1);

    // short lock and stall so homing and goto get deep
    set_regs(16'd3, 16'd5, 16'd4);
    random_phase(700, 7);
    // low extremes
    set_regs(16'd0, 16'd1, 16'd1);
    random_phase(400, 3);
    // high extremes: homing too short and long locks
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(250, 6);
    set_regs(16'd2, 16'd4, 16'd30);
    random_phase(650, 6);

    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
